// ===== sv/spq_pkg.sv =====
// Shared constants, codes and types for the sorted priority queue.
// Used by spq_cell and sorted_priority_queue_remove_by_id; no dependencies.
package spq_pkg;

  localparam int CAPACITY = 16;
  localparam int ID_W = 16;
  localparam int PRI_W = 8;
  localparam int CMD_W = 2;
  localparam int STATUS_W = 2;
  localparam int COUNT_OUT_W = 5;
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int IDX_W = $clog2(CAPACITY);

  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_POP = 2'd1;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd3;

  typedef struct packed {
    logic [ID_W-1:0] id;
    logic [PRI_W-1:0] pri;
  } entry_t;

  // Command broadcast to every cell of the row.
  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic [ID_W-1:0] id;
    logic [PRI_W-1:0] pri;
    logic [CNT_W-1:0] count;
    logic load;
  } ctrl_t;

endpackage

// ===== sv/sorted_priority_queue_remove_by_id.sv =====
// Sorted priority queue with removal by id, built as a row of spq_cell slots.
// The result is valid in the cycle after the input transfer; one command per cycle.
// Every slot compares in parallel on each accepted command; slots load new entries only when it succeeds.
// Throughput holds while results are taken; a stalled result holds the input off.
// Reset (rst, synchronous) empties the queue and clears out_valid; the result payload is not reset.
module sorted_priority_queue_remove_by_id (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [spq_pkg::CMD_W-1:0]       command,
  input  logic [spq_pkg::ID_W-1:0]        task_id,
  input  logic [spq_pkg::PRI_W-1:0]       priority_req,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [spq_pkg::STATUS_W-1:0]    status,
  output logic [spq_pkg::ID_W-1:0]        removed_id,
  output logic [spq_pkg::PRI_W-1:0]       removed_priority,
  output logic [spq_pkg::COUNT_OUT_W-1:0] entry_count
);

  localparam int CAP = spq_pkg::CAPACITY;
  localparam logic [spq_pkg::CNT_W-1:0] CAP_COUNT = spq_pkg::CNT_W'(CAP);

  logic [spq_pkg::CNT_W-1:0]    count;
  logic [spq_pkg::CNT_W-1:0]    count_next;
  logic [spq_pkg::STATUS_W-1:0] status_next;
  spq_pkg::entry_t              removed_next;
  spq_pkg::ctrl_t               ctrl;
  logic                         in_xfer;
  logic                         shift_ok;

  spq_pkg::entry_t cell_entry [CAP];
  logic            cell_stay [CAP];
  logic            match_chain [CAP+1];
  spq_pkg::entry_t found_chain [CAP+1];

  assign in_ready = !out_valid || out_ready;
  assign in_xfer = in_valid && in_ready;

  assign match_chain[0] = 1'b0;
  assign found_chain[0] = '0;

  always_comb begin
    count_next = count;
    status_next = spq_pkg::ST_OK;
    removed_next = '0;
    shift_ok = 1'b0;
    unique case (command)
      spq_pkg::CMD_INSERT: begin
        if (count == CAP_COUNT) begin
          status_next = spq_pkg::ST_FULL;
        end else begin
          count_next = count + 1'b1;
          shift_ok = 1'b1;
        end
      end
      spq_pkg::CMD_POP: begin
        if (count == '0) begin
          status_next = spq_pkg::ST_EMPTY;
        end else begin
          count_next = count - 1'b1;
          removed_next = cell_entry[0];
          shift_ok = 1'b1;
        end
      end
      spq_pkg::CMD_REMOVE: begin
        if (count == '0) begin
          status_next = spq_pkg::ST_EMPTY;
        end else if (!match_chain[CAP]) begin
          status_next = spq_pkg::ST_NOT_FOUND;
        end else begin
          count_next = count - 1'b1;
          removed_next = found_chain[CAP];
          shift_ok = 1'b1;
        end
      end
      default: begin
        count_next = count;
      end
    endcase
  end

  assign ctrl = '{cmd: command, id: task_id, pri: priority_req, count: count,
                  load: in_xfer && shift_ok};

  for (genvar i = 0; i < CAP; i++) begin : g_cell
    spq_pkg::entry_t prev_e;
    logic            prev_s;
    spq_pkg::entry_t next_e;

    if (i == 0) begin : g_first
      assign prev_e = '0;
      assign prev_s = 1'b1;
    end else begin : g_mid
      assign prev_e = cell_entry[i-1];
      assign prev_s = cell_stay[i-1];
    end

    if (i == CAP - 1) begin : g_last
      assign next_e = cell_entry[i];
    end else begin : g_inner
      assign next_e = cell_entry[i+1];
    end

    spq_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .idx        (spq_pkg::IDX_W'(i)),
      .prev_entry (prev_e),
      .prev_stay  (prev_s),
      .next_entry (next_e),
      .match_in   (match_chain[i]),
      .found_in   (found_chain[i]),
      .entry      (cell_entry[i]),
      .stay       (cell_stay[i]),
      .match_out  (match_chain[i+1]),
      .found_out  (found_chain[i+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      out_valid <= 1'b0;
    end else begin
      if (in_xfer) begin
        count <= count_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result payload; held while the result waits for transfer.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      status <= status_next;
      removed_id <= removed_next.id;
      removed_priority <= removed_next.pri;
      entry_count <= spq_pkg::COUNT_OUT_W'(count_next);
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CAP_COUNT)
    else $error("entry count above capacity");

  a_pop_dec: assert property (@(posedge clk) disable iff (rst)
    in_xfer && command == spq_pkg::CMD_POP && count != '0 |=>
      count == $past(count) - 1'b1)
    else $error("pop did not drop one entry");

  a_full_flag: assert property (@(posedge clk) disable iff (rst)
    in_xfer && command == spq_pkg::CMD_INSERT && count == CAP_COUNT |=>
      status == spq_pkg::ST_FULL && count == CAP_COUNT)
    else $error("insert into full queue not flagged");

  a_zero_removed: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != spq_pkg::ST_OK |->
      removed_id == '0 && removed_priority == '0)
    else $error("removed fields set on failed command");

endmodule

// ===== sv/spq_cell.sv =====
// One slot of the sorted queue: holds an entry and shifts to or from its neighbors.
// Depends on spq_pkg.
module spq_cell (
  input  logic                    clk,
  input  spq_pkg::ctrl_t          ctrl,
  input  logic [spq_pkg::IDX_W-1:0] idx,
  input  spq_pkg::entry_t         prev_entry,
  input  logic                    prev_stay,
  input  spq_pkg::entry_t         next_entry,
  input  logic                    match_in,
  input  spq_pkg::entry_t         found_in,
  output spq_pkg::entry_t         entry,
  output logic                    stay,
  output logic                    match_out,
  output spq_pkg::entry_t         found_out
);

  logic            occupied;
  logic            my_match;
  spq_pkg::entry_t entry_next;

  assign occupied = spq_pkg::CNT_W'(idx) < ctrl.count;
  assign stay = occupied && (entry.pri >= ctrl.pri);
  // Only the first matching slot, counted from the front, is taken out.
  assign my_match = occupied && (entry.id == ctrl.id) && !match_in;
  assign match_out = match_in || my_match;
  assign found_out = my_match ? entry : found_in;

  always_comb begin
    entry_next = entry;
    unique case (ctrl.cmd)
      spq_pkg::CMD_INSERT: begin
        if (!stay) begin
          if (prev_stay) begin
            entry_next = '{id: ctrl.id, pri: ctrl.pri};
          end else begin
            entry_next = prev_entry;
          end
        end
      end
      spq_pkg::CMD_POP: begin
        entry_next = next_entry;
      end
      spq_pkg::CMD_REMOVE: begin
        // Close the gap left by the match.
        if (match_out) begin
          entry_next = next_entry;
        end
      end
      default: begin
        entry_next = entry;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      entry <= entry_next;
    end
  end

endmodule
